FILE: rtl/ppdc_pkg.sv
// ----------------------------------------------------------------------------
// ppdc_pkg
// Shared types and constants for the pwm period and duty calculator.
// ----------------------------------------------------------------------------
package ppdc_pkg;

  localparam int DIV_W      = 27;   // clock and frequency width
  localparam int TOP_W      = 16;
  localparam int DUTY_W     = 8;
  localparam int CODE_W     = 3;
  localparam int NUM_W      = 25;   // duty * (top + 1)
  localparam int PROD_W     = 50;
  localparam int RECIP_SH   = 32;
  localparam logic [NUM_W-1:0] RECIP_255 = 25'h1010102;  // ceil(2^32 / 255)
  localparam logic [DUTY_W-1:0] DUTY_FULL = 8'd255;
  localparam logic [NUM_W-1:0]  CEIL_ADD  = 25'd254;
  localparam int NUM_PRESC  = 5;
  localparam logic [CODE_W-1:0] CODE_MAX = 3'd4;
  localparam int TOP_LIMIT_DEF = 65535;
  localparam int CFG_IDX_W  = 2;
  localparam logic [DIV_W-1:0] CLOCK_RST = 27'd16000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLOCK_HZ  = 2'd0,
    CFG_WAVE_MODE = 2'd1,
    CFG_POL_A     = 2'd2,
    CFG_POL_B     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    POL_NONINV  = 2'd0,
    POL_INV     = 2'd1,
    POL_DISABLE = 2'd2,
    POL_UNUSED  = 2'd3
  } pol_t;

  // shift applied to clock/freq for each prescaler code (fast pwm)
  function automatic logic [3:0] presc_shift(input logic [CODE_W-1:0] code);
    logic [3:0] s;
    case (code)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd3;
      3'd2:    s = 4'd6;
      3'd3:    s = 4'd8;
      default: s = 4'd10;
    endcase
    return s;
  endfunction

  typedef struct packed {
    logic              channel;
    logic [DUTY_W-1:0] duty;
    logic              phase;
    logic              invert;
    logic              fzero;
  } side_t;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dq;       // dividend bits out, quotient bits in
    logic [DIV_W-1:0] divisor;
    side_t            side;
  } div_t;

endpackage

FILE: rtl/ppdc_if.sv
// ----------------------------------------------------------------------------
// ppdc_in_if / ppdc_out_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppdc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          channel;
  logic [ppdc_pkg::DUTY_W-1:0]   duty;
  logic [ppdc_pkg::DIV_W-1:0]    freq_hz;
  modport source (output valid, channel, duty, freq_hz, input ready);
  modport sink   (input valid, channel, duty, freq_hz, output ready);
endinterface

interface ppdc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          channel_out;
  logic [ppdc_pkg::CODE_W-1:0]   prescaler_code;
  logic [ppdc_pkg::TOP_W-1:0]    period_top;
  logic [ppdc_pkg::TOP_W-1:0]    compare_value;
  logic                          range_error;
  modport source (output valid, channel_out, prescaler_code, period_top, compare_value,
                  range_error, input ready);
  modport sink   (input valid, channel_out, prescaler_code, period_top, compare_value,
                  range_error, output ready);
endinterface

FILE: rtl/ppdc_div_cell.sv
// ----------------------------------------------------------------------------
// ppdc_div_cell
// One restoring division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module ppdc_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  input  ppdc_pkg::div_t   up_data,
  output logic             up_ready,
  output logic             dn_valid,
  output ppdc_pkg::div_t   dn_data,
  input  logic             dn_ready
);

  logic                        v_r;
  ppdc_pkg::div_t              d_r, d_nxt;
  logic [ppdc_pkg::DIV_W:0]    trial;
  logic                        ge;

  always_comb begin
    trial = {up_data.rem, up_data.dq[ppdc_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, up_data.divisor};
    d_nxt = up_data;
    d_nxt.rem = ge ? ppdc_pkg::DIV_W'(trial - {1'b0, up_data.divisor})
                   : ppdc_pkg::DIV_W'(trial);
    d_nxt.dq  = {up_data.dq[ppdc_pkg::DIV_W-2:0], ge};
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule

FILE: rtl/ppdc_post.sv
// ----------------------------------------------------------------------------
// ppdc_post
// Prescaler pick, duty scaling by 1/255 and compare rules, four stages.
// ----------------------------------------------------------------------------
module ppdc_post #(
  parameter int TOP_LIMIT = ppdc_pkg::TOP_LIMIT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  ppdc_pkg::div_t       up_data,
  output logic                 up_ready,
  ppdc_out_if.source           out_ch
);

  typedef struct packed {
    ppdc_pkg::side_t                side;
    logic [ppdc_pkg::CODE_W-1:0]    code;
    logic [ppdc_pkg::TOP_W-1:0]     top;
    logic                           err;
  } sel_t;

  typedef struct packed {
    sel_t                        s;
    logic [ppdc_pkg::NUM_W-1:0]  num;
  } num_t;

  typedef struct packed {
    sel_t                        s;
    logic [ppdc_pkg::TOP_W:0]    fl;
    logic [ppdc_pkg::TOP_W:0]    ce;
  } quo_t;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rd1, rd2, rd3, rd4;
  sel_t s1_r, s1_nxt;
  num_t s2_r, s2_nxt;
  quo_t s3_r, s3_nxt;
  logic [ppdc_pkg::TOP_W-1:0] cmp_r, cmp_nxt;
  sel_t s4_r;

  // stage 1: smallest prescaler whose top stays under the limit
  always_comb begin
    logic [ppdc_pkg::DIV_W-1:0] lim;
    logic [ppdc_pkg::DIV_W-1:0] q;
    logic                       found;
    lim   = up_data.side.phase ? ppdc_pkg::DIV_W'(TOP_LIMIT - 1) : ppdc_pkg::DIV_W'(TOP_LIMIT);
    found = 1'b0;
    s1_nxt.side = up_data.side;
    s1_nxt.code = ppdc_pkg::CODE_MAX;
    s1_nxt.top  = ppdc_pkg::TOP_W'(TOP_LIMIT);
    s1_nxt.err  = 1'b1;
    for (int k = 0; k < ppdc_pkg::NUM_PRESC; k++) begin
      q = up_data.dq >> (ppdc_pkg::presc_shift(ppdc_pkg::CODE_W'(k)) +
                         4'(up_data.side.phase));
      if (!found && !up_data.side.fzero && q < lim) begin
        found       = 1'b1;
        s1_nxt.code = ppdc_pkg::CODE_W'(k);
        s1_nxt.top  = q[ppdc_pkg::TOP_W-1:0];
        s1_nxt.err  = 1'b0;
      end
    end
  end

  // stage 2: numerator
  always_comb begin
    logic [ppdc_pkg::TOP_W:0] m;
    m = s1_r.side.phase ? {1'b0, s1_r.top} : ({1'b0, s1_r.top} + 1'b1);
    s2_nxt.s   = s1_r;
    s2_nxt.num = ppdc_pkg::NUM_W'(s1_r.side.duty) * ppdc_pkg::NUM_W'(m);
  end

  // stage 3: floor and ceiling of num/255 by reciprocal
  always_comb begin
    logic [ppdc_pkg::PROD_W-1:0] pf, pc;
    pf = ppdc_pkg::PROD_W'(s2_r.num) * ppdc_pkg::PROD_W'(ppdc_pkg::RECIP_255);
    pc = ppdc_pkg::PROD_W'(s2_r.num + ppdc_pkg::CEIL_ADD) *
         ppdc_pkg::PROD_W'(ppdc_pkg::RECIP_255);
    s3_nxt.s  = s2_r.s;
    s3_nxt.fl = pf[ppdc_pkg::RECIP_SH +: ppdc_pkg::TOP_W+1];
    s3_nxt.ce = pc[ppdc_pkg::RECIP_SH +: ppdc_pkg::TOP_W+1];
  end

  // stage 4: compare rules
  always_comb begin
    logic [ppdc_pkg::TOP_W:0] top_x;
    logic                     ce_big;
    top_x  = {1'b0, s3_r.s.top};
    ce_big = s3_r.ce > top_x;
    if (!s3_r.s.side.invert) begin
      if (s3_r.s.side.phase) begin
        cmp_nxt = s3_r.fl[ppdc_pkg::TOP_W-1:0];
      end else if (s3_r.s.side.duty == '0 || s3_r.fl == '0) begin
        cmp_nxt = '0;
      end else begin
        cmp_nxt = ppdc_pkg::TOP_W'(s3_r.fl - 1'b1);
      end
    end else begin
      if (ce_big || (!s3_r.s.side.phase && s3_r.s.side.duty == ppdc_pkg::DUTY_FULL)) begin
        cmp_nxt = '0;
      end else begin
        cmp_nxt = ppdc_pkg::TOP_W'(top_x - s3_r.ce);
      end
    end
  end

  assign rd4      = !v4_r || out_ch.ready;
  assign rd3      = !v3_r || rd4;
  assign rd2      = !v2_r || rd3;
  assign rd1      = !v1_r || rd2;
  assign up_ready = rd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rd1) v1_r <= up_valid;
      if (rd2) v2_r <= v1_r;
      if (rd3) v3_r <= v2_r;
      if (rd4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd1) s1_r <= s1_nxt;
    if (rd2) s2_r <= s2_nxt;
    if (rd3) s3_r <= s3_nxt;
    if (rd4) begin
      s4_r  <= s3_r.s;
      cmp_r <= cmp_nxt;
    end
  end

  assign out_ch.valid          = v4_r;
  assign out_ch.channel_out    = s4_r.side.channel;
  assign out_ch.prescaler_code = s4_r.code;
  assign out_ch.period_top     = s4_r.top;
  assign out_ch.compare_value  = cmp_r;
  assign out_ch.range_error    = s4_r.err;

endmodule

FILE: rtl/pwm_period_duty_calculator.sv
// ----------------------------------------------------------------------------
// pwm_period_duty_calculator
// Prescaler, period top and compare value from channel, duty and frequency.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the result side does not stall.
// clock_hz/freq_hz is found by a row of 27 division cells, one quotient bit
// each, followed by four stages that pick the prescaler, form duty*(top+1) or
// duty*top, divide by 255 through a reciprocal multiply and apply the compare
// rules. A request for a disabled channel is taken and gives no result.
// The user must write registers only while idle; the block does not enforce it.
module pwm_period_duty_calculator #(
  parameter int TOP_LIMIT = ppdc_pkg::TOP_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ppdc_in_if.sink                           in_ch,
  ppdc_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [ppdc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppdc_pkg::DIV_W-1:0]        cfg_data
);

  logic [ppdc_pkg::DIV_W-1:0] clock_hz_r;
  logic                       wave_mode_r;
  logic [1:0]                 pol_a_r, pol_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r  <= ppdc_pkg::CLOCK_RST;
      wave_mode_r <= 1'b0;
      pol_a_r     <= ppdc_pkg::POL_NONINV;
      pol_b_r     <= ppdc_pkg::POL_NONINV;
    end else if (cfg_we) begin
      unique case (ppdc_pkg::cfg_idx_t'(cfg_index))
        ppdc_pkg::CFG_CLOCK_HZ:  clock_hz_r  <= cfg_data;
        ppdc_pkg::CFG_WAVE_MODE: wave_mode_r <= cfg_data[0];
        ppdc_pkg::CFG_POL_A:     pol_a_r     <= cfg_data[1:0];
        ppdc_pkg::CFG_POL_B:     pol_b_r     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  localparam int NCELL = ppdc_pkg::DIV_W;

  logic           c_valid [NCELL+1];
  logic           c_ready [NCELL+1];
  ppdc_pkg::div_t c_data  [NCELL+1];
  logic [1:0]     pol;
  logic           enabled;

  assign pol     = in_ch.channel ? pol_b_r : pol_a_r;
  assign enabled = (pol == ppdc_pkg::POL_NONINV) || (pol == ppdc_pkg::POL_INV);

  // disabled beats are taken but not sent down the row
  always_comb begin
    c_valid[0]              = in_ch.valid && enabled;
    c_data[0].rem           = '0;
    c_data[0].dq            = clock_hz_r;
    c_data[0].divisor       = in_ch.freq_hz;
    c_data[0].side.channel  = in_ch.channel;
    c_data[0].side.duty     = in_ch.duty;
    c_data[0].side.phase    = wave_mode_r;
    c_data[0].side.invert   = (pol == ppdc_pkg::POL_INV);
    c_data[0].side.fzero    = (in_ch.freq_hz == '0);
  end
  assign in_ch.ready = c_ready[0];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ppdc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[i]),
      .up_data  (c_data[i]),
      .up_ready (c_ready[i]),
      .dn_valid (c_valid[i+1]),
      .dn_data  (c_data[i+1]),
      .dn_ready (c_ready[i+1])
    );
  end

  ppdc_post #(.TOP_LIMIT(TOP_LIMIT)) u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (c_valid[NCELL]),
    .up_data  (c_data[NCELL]),
    .up_ready (c_ready[NCELL]),
    .out_ch   (out_ch)
  );

  a_err_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.range_error |->
      out_ch.prescaler_code == ppdc_pkg::CODE_MAX &&
      out_ch.period_top == ppdc_pkg::TOP_W'(TOP_LIMIT))
    else $error("range error without saturated top");

  a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.range_error |->
      out_ch.period_top < ppdc_pkg::TOP_W'(TOP_LIMIT))
    else $error("top at or above limit");

  a_cmp_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.compare_value <= out_ch.period_top)
    else $error("compare value above top");

endmodule

FILE: dv/pwm_period_duty_calculator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_period_duty_calculator_tb
// Self-checking bench for the pwm prescaler, period top and compare calculator.
// ----------------------------------------------------------------------------
// Requests go through a queue-fed driver, and a monitor predicts each accepted
// request and checks the result beats in order. The run steps through several
// register settings, both wave modes and every polarity, with random gaps on
// both handshakes.
module pwm_period_duty_calculator_tb;

  localparam logic MODE_FAST  = 1'b0;
  localparam logic MODE_PHASE = 1'b1;
  localparam int   DRAIN_CYC  = 45;     // pipeline is 31 deep
  localparam int   STALL_MAX  = 5000;
  localparam int   PHASE_ITEMS = 200;

  typedef struct packed {
    logic                        channel;
    logic [ppdc_pkg::DUTY_W-1:0] duty;
    logic [ppdc_pkg::DIV_W-1:0]  freq_hz;
  } pwm_req_t;

  typedef struct packed {
    logic                        channel_out;
    logic [ppdc_pkg::CODE_W-1:0] prescaler_code;
    logic [ppdc_pkg::TOP_W-1:0]  period_top;
    logic [ppdc_pkg::TOP_W-1:0]  compare_value;
    logic                        range_error;
  } pwm_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ppdc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ppdc_pkg::DIV_W-1:0] cfg_data;

  ppdc_in_if  in_if();
  ppdc_out_if out_if();

  pwm_period_duty_calculator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow copy of the registers
  logic [ppdc_pkg::DIV_W-1:0] sh_clock;
  logic                       sh_mode;
  ppdc_pkg::pol_t             sh_pol_a;
  ppdc_pkg::pol_t             sh_pol_b;

  pwm_req_t pending_reqs[$];
  pwm_res_t expected_res[$];
  int  fail_cnt;
  int  idle_cycles;
  bit  in_fire;
  int  in_gap;
  int  out_gap;
  bit  no_idle;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // prescaler search then compare rules; returns 0 for a disabled channel
  function automatic bit calc_pwm(input pwm_req_t rq, output pwm_res_t rs);
    logic [63:0] presc_div [5];
    logic [63:0] denom, lim, top, num, fl, ce, cmp, duty;
    logic [2:0]  code;
    logic        err;
    bit          found;
    ppdc_pkg::pol_t pol;
    presc_div = '{64'd1, 64'd8, 64'd64, 64'd256, 64'd1024};
    pol   = rq.channel ? sh_pol_b : sh_pol_a;
    duty  = 64'(rq.duty);
    code  = ppdc_pkg::CODE_MAX;
    top   = 64'(ppdc_pkg::TOP_LIMIT_DEF);
    err   = 1'b1;
    found = 1'b0;
    if (pol != ppdc_pkg::POL_NONINV && pol != ppdc_pkg::POL_INV) return 1'b0;
    if (rq.freq_hz != '0) begin
      lim = (sh_mode == MODE_PHASE) ? 64'(ppdc_pkg::TOP_LIMIT_DEF - 1)
                                    : 64'(ppdc_pkg::TOP_LIMIT_DEF);
      for (int i = 0; i < ppdc_pkg::NUM_PRESC; i++) begin
        denom = 64'(rq.freq_hz) * presc_div[i] * ((sh_mode == MODE_PHASE) ? 64'd2 : 64'd1);
        if (!found && 64'(sh_clock) < lim * denom) begin
          found = 1'b1;
          code  = 3'(i);
          top   = 64'(sh_clock) / denom;
          err   = 1'b0;
        end
      end
    end
    if (sh_mode == MODE_FAST) begin
      num = duty * (top + 64'd1);
      if (pol == ppdc_pkg::POL_NONINV) begin
        fl  = num / 64'd255;
        cmp = (duty == 0 || fl == 0) ? 64'd0 : fl - 64'd1;
      end else begin
        ce  = (num + 64'd254) / 64'd255;
        cmp = (duty == 64'd255 || ce > top) ? 64'd0 : top - ce;
      end
    end else begin
      num = duty * top;
      if (pol == ppdc_pkg::POL_NONINV) begin
        cmp = num / 64'd255;
      end else begin
        ce  = (num + 64'd254) / 64'd255;
        cmp = (ce > top) ? 64'd0 : top - ce;
      end
    end
    rs.channel_out    = rq.channel;
    rs.prescaler_code = code;
    rs.period_top     = top[ppdc_pkg::TOP_W-1:0];
    rs.compare_value  = cmp[ppdc_pkg::TOP_W-1:0];
    rs.range_error    = err;
    return 1'b1;
  endfunction

  // driver: request beats change on the falling edge
  always @(negedge clk) begin
    if (rst_n && (in_fire || !in_if.valid)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        pwm_req_t rq;
        rq = pending_reqs.pop_front();
        in_if.valid   <= 1'b1;
        in_if.channel <= rq.channel;
        in_if.duty    <= rq.duty;
        in_if.freq_hz <= rq.freq_hz;
        in_gap <= rand_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap <= rand_gap();
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    pwm_req_t rq;
    pwm_res_t rs;
    pwm_res_t exp_r;
    bit out_fire;
    in_fire  = rst_n && in_if.valid && in_if.ready;
    out_fire = rst_n && out_if.valid && out_if.ready;
    if (in_fire) begin
      rq.channel = in_if.channel;
      rq.duty    = in_if.duty;
      rq.freq_hz = in_if.freq_hz;
      if (calc_pwm(rq, rs)) expected_res.push_back(rs);
    end
    if (out_fire) begin
      if (expected_res.size() == 0) begin
        $error("result beat with nothing expected");
        fail_cnt++;
      end else begin
        exp_r = expected_res.pop_front();
        if (out_if.channel_out !== exp_r.channel_out) begin
          $error("channel_out exp %0d got %0d", exp_r.channel_out, out_if.channel_out);
          fail_cnt++;
        end
        if (out_if.prescaler_code !== exp_r.prescaler_code) begin
          $error("prescaler_code exp %0d got %0d", exp_r.prescaler_code,
                 out_if.prescaler_code);
          fail_cnt++;
        end
        if (out_if.period_top !== exp_r.period_top) begin
          $error("period_top exp %0d got %0d", exp_r.period_top, out_if.period_top);
          fail_cnt++;
        end
        if (out_if.compare_value !== exp_r.compare_value) begin
          $error("compare_value exp %0d got %0d", exp_r.compare_value,
                 out_if.compare_value);
          fail_cnt++;
        end
        if (out_if.range_error !== exp_r.range_error) begin
          $error("range_error exp %0d got %0d", exp_r.range_error, out_if.range_error);
          fail_cnt++;
        end
      end
    end
    if (in_fire || out_fire) begin
      idle_cycles = 0;
    end else if (rst_n) begin
      idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input ppdc_pkg::cfg_idx_t idx,
                           input logic [ppdc_pkg::DIV_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    case (idx)
      ppdc_pkg::CFG_CLOCK_HZ:  sh_clock = val;
      ppdc_pkg::CFG_WAVE_MODE: sh_mode  = val[0];
      ppdc_pkg::CFG_POL_A:     sh_pol_a = ppdc_pkg::pol_t'(val[1:0]);
      default:                 sh_pol_b = ppdc_pkg::pol_t'(val[1:0]);
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic setup(input logic [ppdc_pkg::DIV_W-1:0] clk_hz, input logic mode,
                       input ppdc_pkg::pol_t pa, input ppdc_pkg::pol_t pb);
    write_reg(ppdc_pkg::CFG_CLOCK_HZ, clk_hz);
    write_reg(ppdc_pkg::CFG_WAVE_MODE, ppdc_pkg::DIV_W'(mode));
    write_reg(ppdc_pkg::CFG_POL_A, ppdc_pkg::DIV_W'(pa));
    write_reg(ppdc_pkg::CFG_POL_B, ppdc_pkg::DIV_W'(pb));
  endtask

  // sender holds off until every expected beat is back
  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_if.valid && expected_res.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic push_req(input logic ch, input logic [ppdc_pkg::DUTY_W-1:0] d,
                          input logic [ppdc_pkg::DIV_W-1:0] f);
    pwm_req_t rq;
    rq.channel = ch;
    rq.duty    = d;
    rq.freq_hz = f;
    pending_reqs.push_back(rq);
  endtask

  task automatic push_random(input int n);
    logic [ppdc_pkg::DIV_W-1:0] f;
    logic [ppdc_pkg::DUTY_W-1:0] d;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) f = '0;
      else if (r == 1) f = ppdc_pkg::DIV_W'(100000000);
      else if (r < 6) f = ppdc_pkg::DIV_W'($urandom_range(0, 100000000));
      else f = ppdc_pkg::DIV_W'($urandom_range(1, 100000000) >> $urandom_range(0, 26));
      r = $urandom_range(0, 9);
      d = (r == 0) ? 8'd0 : (r == 1) ? ppdc_pkg::DUTY_FULL : ppdc_pkg::DUTY_W'($urandom);
      push_req($urandom_range(0, 1), d, f);
    end
  endtask

  initial begin
    ppdc_pkg::pol_t pa, pb;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = ppdc_pkg::CFG_CLOCK_HZ;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.channel = 1'b0;
    in_if.duty   = '0;
    in_if.freq_hz = '0;
    out_if.ready = 1'b0;
    in_gap = 0;
    out_gap = 0;
    fail_cnt = 0;
    idle_cycles = 0;
    in_fire = 1'b0;
    no_idle = 1'b0;
    sh_clock = ppdc_pkg::CLOCK_RST;
    sh_mode  = MODE_FAST;
    sh_pol_a = ppdc_pkg::POL_NONINV;
    sh_pol_b = ppdc_pkg::POL_NONINV;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset settings: extremes of duty and frequency
    push_req(1'b0, 8'd0,    '0);
    push_req(1'b1, ppdc_pkg::DUTY_FULL, '0);
    push_req(1'b0, ppdc_pkg::DUTY_FULL, 27'd1);
    push_req(1'b1, 8'd0,    27'd1);
    push_req(1'b0, 8'd128,  27'd100000000);
    push_req(1'b1, 8'd1,    27'd100000000);
    push_req(1'b0, 8'd77,   27'd245);
    push_req(1'b1, 8'd254,  27'd244);
    push_req(1'b0, 8'd200,  27'd31);
    push_req(1'b1, 8'd3,    27'd1000);
    drain();
    // too low a frequency, inverting A and disabled B
    setup(27'd100000000, MODE_FAST, ppdc_pkg::POL_INV, ppdc_pkg::POL_DISABLE);
    push_req(1'b0, 8'd100, 27'd1);
    push_req(1'b0, ppdc_pkg::DUTY_FULL, 27'd1);
    push_req(1'b0, 8'd0, '0);
    push_req(1'b1, 8'd50, 27'd1000);
    push_req(1'b0, 8'd254, 27'd100000000);
    drain();
    // phase correct, unused code on A
    setup(27'd100000000, MODE_PHASE, ppdc_pkg::POL_UNUSED, ppdc_pkg::POL_INV);
    push_req(1'b0, 8'd10, 27'd500);
    push_req(1'b1, 8'd0, 27'd1);
    push_req(1'b1, ppdc_pkg::DUTY_FULL, '0);
    push_req(1'b1, 8'd128, 27'd100000000);
    push_req(1'b1, 8'd1, 27'd2000);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      logic [ppdc_pkg::DIV_W-1:0] ck;
      int r;
      r = $urandom_range(0, 4);
      ck = (ph == 0) ? 27'd1 : (ph == 1) ? 27'd100000000 :
           (r == 0) ? ppdc_pkg::CLOCK_RST : ppdc_pkg::DIV_W'($urandom_range(1, 100000000));
      pa = ($urandom_range(0, 7) == 0) ? ppdc_pkg::pol_t'($urandom_range(2, 3))
                                       : ppdc_pkg::pol_t'($urandom_range(0, 1));
      pb = ppdc_pkg::pol_t'($urandom_range(0, 1));
      no_idle = (ph % 3 == 2);
      setup(ck, logic'(ph % 2), pa, pb);
      push_random(PHASE_ITEMS);
      drain();
    end

    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: pwm_period_duty_calculator.f
rtl/ppdc_pkg.sv
rtl/ppdc_if.sv
rtl/ppdc_div_cell.sv
rtl/ppdc_post.sv
rtl/pwm_period_duty_calculator.sv
dv/pwm_period_duty_calculator_tb.sv
